// ----- rtl/afr_pkg.sv -----
// Shared types, constants and helpers of the affine rotate pixel fetch block.
// Used by every module in rtl; depends on nothing.
package afr_pkg;

  localparam int unsigned IMG_WIDTH   = 128;
  localparam int unsigned IMG_HEIGHT  = 128;
  localparam int unsigned STORE_DEPTH = 16384;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned COORD_W     = 7;
  localparam int unsigned PIX_W       = 16;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned COEF_W      = 19;
  localparam int unsigned OFFS_W      = 26;
  localparam int unsigned STRIDE_W    = 8;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned ROUND_HALF  = 32768;
  localparam int unsigned PROD_W      = COEF_W + COORD_W + 1;
  localparam int unsigned SUM_W       = PROD_W + 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 26;

  localparam logic signed [COEF_W-1:0] COEF_ONE      = COEF_W'(65536);
  localparam logic [STRIDE_W-1:0]      STRIDE_RESET  = STRIDE_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XX    = 3'd0,
    REG_COEF_XY    = 3'd1,
    REG_OFFSET_X   = 3'd2,
    REG_COEF_YX    = 3'd3,
    REG_COEF_YY    = 3'd4,
    REG_OFFSET_Y   = 3'd5,
    REG_SRC_STRIDE = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_MAP  = 1'b1
  } action_e;

  typedef struct packed {
    logic                 action;
    logic [ADDR_W-1:0]    load_index;
    logic [COLOR_W-1:0]   color_word;
    logic [COORD_W-1:0]   out_col;
    logic [COORD_W-1:0]   out_row;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_xx;
    logic signed [COEF_W-1:0] coef_xy;
    logic signed [OFFS_W-1:0] offset_x;
    logic signed [COEF_W-1:0] coef_yx;
    logic signed [COEF_W-1:0] coef_yy;
    logic signed [OFFS_W-1:0] offset_y;
    logic [STRIDE_W-1:0]      src_stride;
  } cfg_t;

  // Item at the store stage: a write for a load, a read for a map.
  typedef struct packed {
    logic               is_map;
    logic [ADDR_W-1:0]  addr;
    logic [PIX_W-1:0]   rgb;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } st_item_t;

  function automatic logic [PIX_W-1:0] to_rgb565(input logic [COLOR_W-1:0] c);
    return {c[7:3], c[15:10], c[31:27]};
  endfunction

endpackage

// ----- rtl/affine_rotate_pixel_fetch_core.sv -----
// Top level of the affine rotate pixel fetch block.
// Depends on afr_pkg, afr_cfg, afr_xform and afr_pix_store.
//
// The block takes one item per clock unless a map result held at the output
// stalls it. A load item writes its color, converted to RGB565, into the
// 16384-entry source image memory and gives no result. A map item runs its
// output column and row through the programmed Q16 affine transform, rounds
// half away from zero, clamps to the image and returns the stored pixel with
// the source coordinates used; its result passes the input register, the
// product, sum, rounding and address stages and the registered memory read.
// Items leave in the order they arrive, and a map reads every load accepted
// before it. The memory is not cleared by reset: read only entries that have
// been loaded. Write the configuration registers only while no item is in flight.
module affine_rotate_pixel_fetch_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  afr_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output afr_pkg::out_item_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [afr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [afr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import afr_pkg::*;

  cfg_t     cfg;
  in_item_t in_q;
  logic     in_valid_q;
  logic     x_ready;
  logic     st_valid, st_ready;
  st_item_t st_item;

  assign in_ready_o = !in_valid_q || x_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  afr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  afr_xform u_xform (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_q),
    .in_ready_o (x_ready),
    .in_item_i  (in_q),
    .st_valid_o (st_valid),
    .st_ready_i (st_ready),
    .st_item_o  (st_item)
  );

  afr_pix_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .st_valid_i  (st_valid),
    .st_ready_o  (st_ready),
    .st_item_i   (st_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

`ifndef ASSERT_OFF
  a_load_never_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid && !st_item.is_map) |-> st_ready)
    else $error("Load item stalled at the store stage.");

  a_result_from_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(st_valid && st_ready && st_item.is_map))
    else $error("Result appeared without a map item reading the store.");

  a_ready_low_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && !x_ready))
    else $error("Input held off while the input register could take an item.");
`endif

endmodule

// ----- rtl/afr_cfg.sv -----
// Configuration register file: transform coefficients, offsets and stride.
// Depends on afr_pkg.
module afr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [afr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [afr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output afr_pkg::cfg_t                 cfg_o
);
  import afr_pkg::*;

  cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COEF_XX:    cfg_d.coef_xx    = cfg_data_i[COEF_W-1:0];
        REG_COEF_XY:    cfg_d.coef_xy    = cfg_data_i[COEF_W-1:0];
        REG_OFFSET_X:   cfg_d.offset_x   = cfg_data_i[OFFS_W-1:0];
        REG_COEF_YX:    cfg_d.coef_yx    = cfg_data_i[COEF_W-1:0];
        REG_COEF_YY:    cfg_d.coef_yy    = cfg_data_i[COEF_W-1:0];
        REG_OFFSET_Y:   cfg_d.offset_y   = cfg_data_i[OFFS_W-1:0];
        REG_SRC_STRIDE: cfg_d.src_stride = cfg_data_i[STRIDE_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_xx    <= COEF_ONE;
      cfg_q.coef_xy    <= '0;
      cfg_q.offset_x   <= '0;
      cfg_q.coef_yx    <= '0;
      cfg_q.coef_yy    <= COEF_ONE;
      cfg_q.offset_y   <= '0;
      cfg_q.src_stride <= STRIDE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/afr_xform.sv -----
// Coordinate pipeline: products, sums, rounding and clamping, store address.
// Depends on afr_pkg.
module afr_xform (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  afr_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  afr_pkg::in_item_t in_item_i,
  output logic              st_valid_o,
  input  logic              st_ready_i,
  output afr_pkg::st_item_t st_item_o
);
  import afr_pkg::*;

  localparam int unsigned RND_W = SUM_W - FRAC_W;
  localparam int unsigned IDX_W = COORD_W + STRIDE_W + 1;
  localparam logic [RND_W-1:0] COL_MAX = RND_W'(IMG_WIDTH - 1);
  localparam logic [RND_W-1:0] ROW_MAX = RND_W'(IMG_HEIGHT - 1);

  typedef struct packed {
    logic                      is_map;
    logic [ADDR_W-1:0]         load_index;
    logic [PIX_W-1:0]          rgb;
    logic signed [PROD_W-1:0]  p_xx;
    logic signed [PROD_W-1:0]  p_xy;
    logic signed [PROD_W-1:0]  p_yx;
    logic signed [PROD_W-1:0]  p_yy;
  } prod_t;

  typedef struct packed {
    logic                     is_map;
    logic [ADDR_W-1:0]        load_index;
    logic [PIX_W-1:0]         rgb;
    logic signed [SUM_W-1:0]  sx;
    logic signed [SUM_W-1:0]  sy;
  } sum_t;

  typedef struct packed {
    logic               is_map;
    logic [ADDR_W-1:0]  load_index;
    logic [PIX_W-1:0]   rgb;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } crd_t;

  // Rounds half away from zero; anything negative clamps to zero.
  function automatic logic [COORD_W-1:0] round_clamp(input logic signed [SUM_W-1:0] v,
                                                     input logic [RND_W-1:0] lim);
    logic signed [SUM_W-1:0] biased;
    logic [RND_W-1:0]        rnd;
    logic [COORD_W-1:0]      res;
    biased = v + SUM_W'(ROUND_HALF);
    rnd    = biased[SUM_W-1:FRAC_W];
    if (v[SUM_W-1]) begin
      res = '0;
    end else if (rnd > lim) begin
      res = lim[COORD_W-1:0];
    end else begin
      res = rnd[COORD_W-1:0];
    end
    return res;
  endfunction

  logic     v2_q, v3_q, v4_q, v5_q;
  logic     rdy2, rdy3, rdy4, rdy5;
  prod_t    p2_d, p2_q;
  sum_t     p3_d, p3_q;
  crd_t     p4_d, p4_q;
  st_item_t p5_d, p5_q;
  logic signed [PROD_W-1:0] col_s, row_s;
  logic [IDX_W-1:0]         idx_full;

  assign rdy5       = !v5_q || st_ready_i;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = rdy2;
  assign st_valid_o = v5_q;
  assign st_item_o  = p5_q;

  always_comb begin
    col_s           = $signed(PROD_W'(in_item_i.out_col));
    row_s           = $signed(PROD_W'(in_item_i.out_row));
    p2_d.is_map     = (in_item_i.action == ACT_MAP);
    p2_d.load_index = in_item_i.load_index;
    p2_d.rgb        = to_rgb565(in_item_i.color_word);
    p2_d.p_xx       = PROD_W'(cfg_i.coef_xx) * col_s;
    p2_d.p_xy       = PROD_W'(cfg_i.coef_xy) * row_s;
    p2_d.p_yx       = PROD_W'(cfg_i.coef_yx) * col_s;
    p2_d.p_yy       = PROD_W'(cfg_i.coef_yy) * row_s;
  end

  always_comb begin
    p3_d.is_map     = p2_q.is_map;
    p3_d.load_index = p2_q.load_index;
    p3_d.rgb        = p2_q.rgb;
    p3_d.sx = SUM_W'(p2_q.p_xx) + SUM_W'(p2_q.p_xy) + SUM_W'(cfg_i.offset_x);
    p3_d.sy = SUM_W'(p2_q.p_yx) + SUM_W'(p2_q.p_yy) + SUM_W'(cfg_i.offset_y);
  end

  always_comb begin
    p4_d.is_map     = p3_q.is_map;
    p4_d.load_index = p3_q.load_index;
    p4_d.rgb        = p3_q.rgb;
    p4_d.cx         = round_clamp(p3_q.sx, COL_MAX);
    p4_d.cy         = round_clamp(p3_q.sy, ROW_MAX);
  end

  always_comb begin
    idx_full    = IDX_W'(p4_q.cy) * IDX_W'(cfg_i.src_stride) + IDX_W'(p4_q.cx);
    p5_d.is_map = p4_q.is_map;
    p5_d.addr   = p4_q.is_map ? idx_full[ADDR_W-1:0] : p4_q.load_index;
    p5_d.rgb    = p4_q.rgb;
    p5_d.col    = p4_q.cx;
    p5_d.row    = p4_q.cy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy2) v2_q <= in_valid_i;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && in_valid_i) p2_q <= p2_d;
    if (rdy3 && v2_q)       p3_q <= p3_d;
    if (rdy4 && v3_q)       p4_q <= p4_d;
    if (rdy5 && v4_q)       p5_q <= p5_d;
  end

endmodule

// ----- rtl/afr_pix_store.sv -----
// Source image memory with registered read that doubles as the result register.
// Depends on afr_pkg.
module afr_pix_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               st_valid_i,
  output logic               st_ready_o,
  input  afr_pkg::st_item_t  st_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output afr_pkg::out_item_t out_item_o
);
  import afr_pkg::*;

  logic [PIX_W-1:0]   mem_q [STORE_DEPTH];
  logic [PIX_W-1:0]   pix_q;
  logic [COORD_W-1:0] col_q, row_q;
  logic               ov_q;
  logic               wr_en, rd_en;

  assign st_ready_o = !st_item_i.is_map || !ov_q || out_ready_i;
  assign wr_en      = st_valid_i && !st_item_i.is_map;
  assign rd_en      = st_valid_i && st_item_i.is_map && st_ready_o;

  assign out_valid_o        = ov_q;
  assign out_item_o.pixel   = pix_q;
  assign out_item_o.src_col = col_q;
  assign out_item_o.src_row = row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[st_item_i.addr] <= st_item_i.rgb;
    end
    if (rd_en) begin
      pix_q <= mem_q[st_item_i.addr];
      col_q <= st_item_i.col;
      row_q <= st_item_i.row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (rd_en) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

endmodule
